// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger
`define IMGF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Condition must hold in the cycle after the trigger
`define IMGF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

// ===== hdl/imgf_pkg.sv =====
package imgf_pkg;

    localparam int MAX_RANGES_DEF = 32;
    localparam int START_W        = 32;
    localparam int END_W          = 33;
    localparam int MC_W           = 6;
    localparam int PADDR_W        = 4;
    localparam int PDATA_W        = 64;

    // Register index taken from paddr[3]
    localparam logic REG_IMAGE_SIZE = 1'b0;

    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_FINISH = 1'b1
    } t_action;

    typedef struct packed {
        t_action              action;
        logic [START_W-1:0]   range_start;
        logic [END_W-1:0]     range_end;
    } t_cmd;

    typedef struct packed {
        logic [END_W-1:0] gap_start;
        logic [END_W-1:0] gap_end;
        logic             no_gap;
        logic [MC_W-1:0]  merged_count;
        logic             overflow;
        logic             last;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_PROC,
        S_TAIL,
        S_FLUSH
    } t_state;

endpackage

// ===== hdl/imgf_front.sv =====
module imgf_front
    import imgf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic               i_action,
    input  logic [START_W-1:0] i_range_start,
    input  logic [START_W-1:0] i_range_length,
    output t_cmd               o_cmd,
    output logic               o_cmd_v,
    input  logic               i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;
    t_cmd       cmd_in;

    // Classify the request and form the 33-bit end without wrap
    always_comb begin
        cmd_in.action      = t_action'(i_action);
        cmd_in.range_start = i_range_start;
        cmd_in.range_end   = {1'b0, i_range_start} + {1'b0, i_range_length};
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_cmd_v = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_cmd_pop && o_cmd_v;

    // Hold payload in the two-entry queue
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

// ===== hdl/imgf_res_queue.sv =====
module imgf_res_queue
    import imgf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_res,
    input  logic    i_res_push,
    output logic    o_res_full,
    output t_result o_head,
    output logic    o_empty,
    input  logic    i_pop
);

    t_result    r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_res_full = (r_cnt == 2'd2);
    assign o_empty    = (r_cnt == 2'd0);
    assign o_head     = r_q[r_rp];
    assign wr         = i_res_push && !o_res_full;
    assign rd         = i_pop && !o_empty;

    // Hold finished results until taken
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

// ===== hdl/imgf_back.sv =====
module imgf_back
    import imgf_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_cmd_v,
    output logic             o_cmd_pop,
    input  logic [END_W-1:0] i_image_size,
    output t_result          o_res,
    output logic             o_res_push,
    input  logic             i_res_full
);

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_RANGES);

    logic [START_W-1:0] mem_s [MAX_RANGES];
    logic [END_W-1:0]   mem_e [MAX_RANGES];

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic               r_dropped, n_dropped;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_rd_v;
    logic [START_W-1:0] r_rd_s;
    logic [END_W-1:0]   r_rd_e;
    logic               r_best_v, n_best_v;
    logic [START_W-1:0] r_best_s, n_best_s;
    logic [END_W-1:0]   r_best_e, n_best_e;
    logic               r_lb_v, n_lb_v;
    logic [START_W-1:0] r_lb_s, n_lb_s;
    logic [END_W-1:0]   r_lb_e, n_lb_e;
    logic               r_pass, n_pass;
    logic               r_cur_v, n_cur_v;
    logic [END_W-1:0]   r_cur_e, n_cur_e;
    logic [MC_W-1:0]    r_m, n_m;
    logic [MC_W-1:0]    r_mc, n_mc;
    logic               r_pend_v, n_pend_v;
    logic [END_W-1:0]   r_pend_s, n_pend_s;
    logic [END_W-1:0]   r_pend_e, n_pend_e;

    logic               mem_we;
    logic               cand_ok;
    logic               gap_v;
    logic [END_W-1:0]   gap_s, gap_e, best_s33, pos;
    logic               stall;

    // Store loaded ranges
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_s[r_count[AW-1:0]] <= i_cmd.range_start;
            mem_e[r_count[AW-1:0]] <= i_cmd.range_end;
        end
    end

    // Registered read of the scanned entry
    always_ff @(posedge i_clk) begin
        r_rd_s <= mem_s[r_idx];
        r_rd_e <= mem_e[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_rd_v    <= 1'b0;
            r_best_v  <= 1'b0;
            r_lb_v    <= 1'b0;
            r_pass    <= 1'b0;
            r_cur_v   <= 1'b0;
            r_pend_v  <= 1'b0;
            r_m       <= '0;
            r_mc      <= '0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_rd_v    <= (r_state == S_SCAN);
            r_best_v  <= n_best_v;
            r_lb_v    <= n_lb_v;
            r_pass    <= n_pass;
            r_cur_v   <= n_cur_v;
            r_pend_v  <= n_pend_v;
            r_m       <= n_m;
            r_mc      <= n_mc;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_s <= n_best_s;
        r_best_e <= n_best_e;
        r_lb_s   <= n_lb_s;
        r_lb_e   <= n_lb_e;
        r_cur_e  <= n_cur_e;
        r_pend_s <= n_pend_s;
        r_pend_e <= n_pend_e;
    end

    // Sequence loads, the selection scans and the gap emission
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_dropped = r_dropped;
        n_idx     = r_idx;
        n_best_v  = r_best_v;
        n_best_s  = r_best_s;
        n_best_e  = r_best_e;
        n_lb_v    = r_lb_v;
        n_lb_s    = r_lb_s;
        n_lb_e    = r_lb_e;
        n_pass    = r_pass;
        n_cur_v   = r_cur_v;
        n_cur_e   = r_cur_e;
        n_m       = r_m;
        n_mc      = r_mc;
        n_pend_v  = r_pend_v;
        n_pend_s  = r_pend_s;
        n_pend_e  = r_pend_e;
        mem_we    = 1'b0;
        o_cmd_pop = 1'b0;
        o_res_push = 1'b0;
        o_res     = '0;
        o_res.merged_count = r_mc;
        o_res.overflow     = r_dropped;
        gap_v     = 1'b0;
        gap_s     = '0;
        gap_e     = '0;
        best_s33  = {1'b0, r_best_s};
        pos       = r_cur_v ? r_cur_e : '0;
        stall     = 1'b0;

        // Keep the smallest key above the lower bound
        cand_ok = r_rd_v
            && (!r_lb_v || {r_rd_s, r_rd_e} > {r_lb_s, r_lb_e})
            && (!r_best_v || {r_rd_s, r_rd_e} < {r_best_s, r_best_e});
        if (cand_ok) begin
            n_best_v = 1'b1;
            n_best_s = r_rd_s;
            n_best_e = r_rd_e;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_v) begin
                    if (i_cmd.action == ACT_FINISH) begin
                        n_pass   = 1'b0;
                        n_cur_v  = 1'b0;
                        n_m      = '0;
                        n_lb_v   = 1'b0;
                        n_best_v = 1'b0;
                        n_pend_v = 1'b0;
                        n_idx    = '0;
                        if (r_count == '0) begin
                            n_pass  = 1'b1;
                            n_mc    = '0;
                            n_state = S_TAIL;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (r_count < CAP) begin
                            mem_we  = 1'b1;
                            n_count = r_count + 1'b1;
                        end else begin
                            n_dropped = 1'b1;
                        end
                        o_cmd_pop = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (CW'(r_idx) == r_count - 1'b1) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_PROC;
            end
            S_PROC: begin
                if (!r_best_v) begin
                    if (!r_pass) begin
                        // First sweep done: the merged count is now known
                        n_mc    = r_m;
                        n_pass  = 1'b1;
                        n_cur_v = 1'b0;
                        n_m     = '0;
                        n_lb_v  = 1'b0;
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_TAIL;
                    end
                end else begin
                    if (!r_cur_v) begin
                        gap_v = (best_s33 != '0);
                        gap_e = best_s33;
                    end else if (r_cur_e < best_s33) begin
                        gap_v = 1'b1;
                        gap_s = r_cur_e;
                        gap_e = best_s33;
                    end
                    stall = r_pass && gap_v && r_pend_v && i_res_full;
                    if (!stall) begin
                        if (!r_cur_v || r_cur_e < best_s33) begin
                            n_cur_v = 1'b1;
                            n_cur_e = r_best_e;
                            n_m     = r_m + 1'b1;
                        end else if (r_best_e > r_cur_e) begin
                            n_cur_e = r_best_e;
                        end
                        if (r_pass && gap_v) begin
                            o_res_push      = r_pend_v;
                            o_res.gap_start = r_pend_s;
                            o_res.gap_end   = r_pend_e;
                            n_pend_v = 1'b1;
                            n_pend_s = gap_s;
                            n_pend_e = gap_e;
                        end
                        n_lb_v   = 1'b1;
                        n_lb_s   = r_best_s;
                        n_lb_e   = r_best_e;
                        n_best_v = 1'b0;
                        n_idx    = '0;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_TAIL: begin
                // Trailing gap up to the image size
                gap_v = (pos < i_image_size);
                stall = gap_v && r_pend_v && i_res_full;
                if (!stall) begin
                    if (gap_v) begin
                        o_res_push      = r_pend_v;
                        o_res.gap_start = r_pend_s;
                        o_res.gap_end   = r_pend_e;
                        n_pend_v = 1'b1;
                        n_pend_s = pos;
                        n_pend_e = i_image_size;
                    end
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res.last = 1'b1;
                    if (r_pend_v) begin
                        o_res.gap_start = r_pend_s;
                        o_res.gap_end   = r_pend_e;
                    end else begin
                        o_res.no_gap = 1'b1;
                    end
                    n_pend_v  = 1'b0;
                    n_count   = '0;
                    n_dropped = 1'b0;
                    o_cmd_pop = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/interval_merge_gap_finder_unit.sv =====
// Interval merge and gap finder. Each load request stores one range (start and
// start plus length, 33 bits); loads past MAX_RANGES are dropped and reported
// as overflow on the next finish. A finish request sorts and merges the stored
// ranges by repeated selection scans over the range memory (one read port, one
// entry per cycle), in two sweeps because every result carries the final
// merged count.
// It then returns each uncovered gap up to image_size, the final one marked
// last, or a single no_gap result. A two-entry request queue in front and a
// two-entry result queue behind let both sides stall on their own. image_size
// is written over the APB port at byte address 0 (64-bit data).
module interval_merge_gap_finder_unit
    import imgf_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_action,
    input  logic [START_W-1:0] i_range_start,
    input  logic [START_W-1:0] i_range_length,
    output logic               empty,
    input  logic               pop,
    output logic [END_W-1:0]   o_gap_start,
    output logic [END_W-1:0]   o_gap_end,
    output logic               o_no_gap,
    output logic [MC_W-1:0]    o_merged_count,
    output logic               o_overflow,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [END_W-1:0] r_image_size;
    t_cmd             cmd;
    logic             cmd_v, cmd_pop;
    t_result          res, head;
    logic             res_push, res_full;

    // Configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= '0;
        end else if (psel && penable && pwrite && pready && paddr[3] == REG_IMAGE_SIZE) begin
            r_image_size <= pwdata[END_W-1:0];
        end
    end
    assign prdata = (paddr[3] == REG_IMAGE_SIZE) ? {{(PDATA_W-END_W){1'b0}}, r_image_size}
                                                 : '0;

    imgf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_action       (i_action),
        .i_range_start  (i_range_start),
        .i_range_length (i_range_length),
        .o_cmd          (cmd),
        .o_cmd_v        (cmd_v),
        .i_cmd_pop      (cmd_pop)
    );

    imgf_back #(.MAX_RANGES(MAX_RANGES)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cmd_v      (cmd_v),
        .o_cmd_pop    (cmd_pop),
        .i_image_size (r_image_size),
        .o_res        (res),
        .o_res_push   (res_push),
        .i_res_full   (res_full)
    );

    imgf_res_queue u_res_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (res),
        .i_res_push (res_push),
        .o_res_full (res_full),
        .o_head     (head),
        .o_empty    (empty),
        .i_pop      (pop)
    );

    assign o_gap_start    = head.gap_start;
    assign o_gap_end      = head.gap_end;
    assign o_no_gap       = head.no_gap;
    assign o_merged_count = head.merged_count;
    assign o_overflow     = head.overflow;
    assign o_last         = head.last;

endmodule

// ===== hdl/imgf_checker.sv =====
`include "assert_macros.svh"

module imgf_checker
    import imgf_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             empty,
    input logic             pop,
    input logic [END_W-1:0] o_gap_start,
    input logic [END_W-1:0] o_gap_end,
    input logic             o_no_gap,
    input logic             o_last
);

    // A waiting result holds until taken
    `IMGF_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_gap_start))

    // A real gap is never empty
    `IMGF_ASSERT_NOW(a_gap_nonempty, i_clk, i_rst_n, !empty && !o_no_gap, o_gap_start < o_gap_end)

    // A no-gap result stands alone and carries zero bounds
    `IMGF_ASSERT_NOW(a_nogap_form, i_clk, i_rst_n, !empty && o_no_gap, o_last && o_gap_start == '0 && o_gap_end == '0)

endmodule

bind interval_merge_gap_finder_unit imgf_checker u_imgf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .empty       (empty),
    .pop         (pop),
    .o_gap_start (o_gap_start),
    .o_gap_end   (o_gap_end),
    .o_no_gap    (o_no_gap),
    .o_last      (o_last)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import imgf_pkg::*;

    localparam int  NRANGE    = MAX_RANGES_DEF;
    localparam int  LIMIT     = 2_000_000;
    localparam int  HOLD_LEN  = 400;
    localparam int  N_RANDOM  = 320;
    localparam logic [END_W-1:0] SIZE_MAX = 33'h1_0000_0000;

    typedef enum logic [1:0] {ROW_LOAD, ROW_FINISH, ROW_SIZE} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [31:0]        start_val;
        logic [31:0]        length_val;
        logic [END_W-1:0]   size_val;
        bit                 typed;
        t_result            typed_res;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic               i_action = ACT_LOAD;
    logic [START_W-1:0] i_range_start = '0;
    logic [START_W-1:0] i_range_length = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [END_W-1:0]   o_gap_start;
    logic [END_W-1:0]   o_gap_end;
    logic               o_no_gap;
    logic [MC_W-1:0]    o_merged_count;
    logic               o_overflow;
    logic               o_last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    interval_merge_gap_finder_unit dut (.*);

    // predictor state
    logic [END_W-1:0] mdl_image_size;
    logic [END_W-1:0] mdl_start [NRANGE];
    logic [END_W-1:0] mdl_end   [NRANGE];
    int               mdl_count;
    bit               mdl_dropped;

    t_result gap_q[$];
    int      errors = 0;
    bit      quiet = 1'b0;
    bit      hold_req = 1'b0;
    int      cycles = 0;
    int      items = 0;

    always #4 i_clk = ~i_clk;

    // Apply one request to the predictor and queue the gaps it yields
    function automatic void predict_gaps(input logic act, input logic [31:0] s,
                                         input logic [31:0] len, output t_result res[$]);
        logic [END_W-1:0] ws [NRANGE];
        logic [END_W-1:0] we [NRANGE];
        logic [END_W-1:0] ts, te, pos;
        int n, m, j;
        t_result r;
        res = {};
        if (act == ACT_LOAD) begin
            if (mdl_count < NRANGE) begin
                mdl_start[mdl_count] = {1'b0, s};
                mdl_end[mdl_count]   = {1'b0, s} + {1'b0, len};
                mdl_count++;
            end else begin
                mdl_dropped = 1'b1;
            end
            return;
        end
        n = mdl_count;
        for (int i = 0; i < n; i++) begin
            ws[i] = mdl_start[i];
            we[i] = mdl_end[i];
        end
        // insertion sort on start, then end
        for (int i = 1; i < n; i++) begin
            ts = ws[i];
            te = we[i];
            j = i;
            while (j > 0 && (ws[j-1] > ts || (ws[j-1] == ts && we[j-1] > te))) begin
                ws[j] = ws[j-1];
                we[j] = we[j-1];
                j--;
            end
            ws[j] = ts;
            we[j] = te;
        end
        // merge overlapping or touching ranges
        m = 0;
        if (n > 0) begin
            j = 0;
            for (int i = 1; i < n; i++) begin
                if (we[j] >= ws[i]) begin
                    if (we[j] < we[i]) we[j] = we[i];
                end else begin
                    j++;
                    ws[j] = ws[i];
                    we[j] = we[i];
                end
            end
            m = j + 1;
        end
        r.no_gap = 1'b0;
        r.merged_count = m[MC_W-1:0];
        r.overflow = mdl_dropped;
        r.last = 1'b0;
        pos = '0;
        for (int i = 0; i < m; i++) begin
            if (pos < ws[i]) begin
                r.gap_start = pos;
                r.gap_end = ws[i];
                res.push_back(r);
            end
            pos = we[i];
        end
        if (pos < mdl_image_size) begin
            r.gap_start = pos;
            r.gap_end = mdl_image_size;
            res.push_back(r);
        end
        if (res.size() == 0) begin
            r.gap_start = '0;
            r.gap_end = '0;
            r.no_gap = 1'b1;
            res.push_back(r);
        end
        res[res.size()-1].last = 1'b1;
        mdl_count = 0;
        mdl_dropped = 1'b0;
    endfunction

    // Offer one request until it is taken, then update the expectations
    task automatic send_request(input logic act, input logic [31:0] s,
                                input logic [31:0] len, input bit typed = 0,
                                input t_result typed_res = '0);
        t_result res[$];
        bit taken;
        @(negedge i_clk);
        push <= 1'b1;
        i_action <= act;
        i_range_start <= s;
        i_range_length <= len;
        do begin
            @(posedge i_clk);
            taken = !full;
        end while (!taken);
        predict_gaps(act, s, len, res);
        if (typed) gap_q.push_back(typed_res);
        else foreach (res[k]) gap_q.push_back(res[k]);
        items++;
        // random gap after the request
        if (!quiet && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat ($urandom_range(1, 14) - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (gap_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Write image_size over the APB port, then read it back
    task automatic write_image_size(input logic [END_W-1:0] val);
        drain_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_IMAGE_SIZE, 3'b000};
        pwdata <= {31'b0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[END_W-1:0] !== val)
            $display("%0t image_size readback: expected %h actual %h", $realtime, val,
                     prdata[END_W-1:0]);
        if (prdata[END_W-1:0] !== val) errors++;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        mdl_image_size = val;
    endtask

    function automatic t_result gap_res(input logic [END_W-1:0] gs, input logic [END_W-1:0] ge,
                                        input logic nog, input int mc, input logic ovf);
        t_result r;
        r.gap_start = gs;
        r.gap_end = ge;
        r.no_gap = nog;
        r.merged_count = mc[MC_W-1:0];
        r.overflow = ovf;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic logic [31:0] pick_value(input bit wide, input int span);
        return wide ? $urandom : $urandom_range(0, span);
    endfunction

    // Result side: pop with random stall bursts and long hold-offs
    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_LEN - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                stall = $urandom_range(1, 14) - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (gap_q.size() == 0) begin
                $display("%0t unexpected result: actual start %h end %h", $realtime,
                         o_gap_start, o_gap_end);
                errors++;
            end else begin
                t_result e;
                e = gap_q.pop_front();
                if (o_gap_start !== e.gap_start) begin
                    $display("%0t gap_start: expected %h actual %h", $realtime,
                             e.gap_start, o_gap_start);
                    errors++;
                end
                if (o_gap_end !== e.gap_end) begin
                    $display("%0t gap_end: expected %h actual %h", $realtime,
                             e.gap_end, o_gap_end);
                    errors++;
                end
                if (o_no_gap !== e.no_gap) begin
                    $display("%0t no_gap: expected %b actual %b", $realtime, e.no_gap, o_no_gap);
                    errors++;
                end
                if (o_merged_count !== e.merged_count) begin
                    $display("%0t merged_count: expected %0d actual %0d", $realtime,
                             e.merged_count, o_merged_count);
                    errors++;
                end
                if (o_overflow !== e.overflow) begin
                    $display("%0t overflow: expected %b actual %b", $realtime,
                             e.overflow, o_overflow);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $display("%0t last: expected %b actual %b", $realtime, e.last, o_last);
                    errors++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        t_row rows[$];
        t_row row;
        int nload, span;
        bit wide;

        mdl_image_size = '0;
        mdl_count = 0;
        mdl_dropped = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        row = '{ROW_FINISH, 0, 0, 0, 1, gap_res(0, 0, 1, 0, 0)};
        rows.push_back(row);
        row = '{ROW_SIZE, 0, 0, SIZE_MAX, 0, '0};
        rows.push_back(row);
        row = '{ROW_FINISH, 0, 0, 0, 1, gap_res(0, SIZE_MAX, 0, 0, 0)};
        rows.push_back(row);
        row = '{ROW_LOAD, 32'h0, 32'hFFFF_FFFF, 0, 0, '0};
        rows.push_back(row);
        row = '{ROW_FINISH, 0, 0, 0, 0, '0};
        rows.push_back(row);
        row = '{ROW_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, '0};
        rows.push_back(row);
        row = '{ROW_LOAD, 32'h0, 32'hFFFF_FFFF, 0, 0, '0};
        rows.push_back(row);
        row = '{ROW_FINISH, 0, 0, 0, 1, gap_res(0, 0, 1, 1, 0)};
        rows.push_back(row);
        row = '{ROW_LOAD, 10, 5, 0, 0, '0};
        rows.push_back(row);
        row = '{ROW_LOAD, 12, 10, 0, 0, '0};
        rows.push_back(row);
        row = '{ROW_LOAD, 30, 0, 0, 0, '0};
        rows.push_back(row);
        row = '{ROW_LOAD, 25, 5, 0, 0, '0};
        rows.push_back(row);
        row = '{ROW_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, '0};
        rows.push_back(row);
        row = '{ROW_FINISH, 0, 0, 0, 0, '0};
        rows.push_back(row);
        row = '{ROW_SIZE, 0, 0, 100, 0, '0};
        rows.push_back(row);
        row = '{ROW_LOAD, 200, 10, 0, 0, '0};
        rows.push_back(row);
        row = '{ROW_LOAD, 40, 20, 0, 0, '0};
        rows.push_back(row);
        row = '{ROW_FINISH, 0, 0, 0, 0, '0};
        rows.push_back(row);
        row = '{ROW_LOAD, 0, 100, 0, 0, '0};
        rows.push_back(row);
        row = '{ROW_FINISH, 0, 0, 0, 1, gap_res(0, 0, 1, 1, 0)};
        rows.push_back(row);
        row = '{ROW_LOAD, 0, 50, 0, 0, '0};
        rows.push_back(row);
        row = '{ROW_FINISH, 0, 0, 0, 1, gap_res(50, 100, 0, 1, 0)};
        rows.push_back(row);

        foreach (rows[r]) begin
            case (rows[r].kind)
                ROW_SIZE:   write_image_size(rows[r].size_val);
                ROW_LOAD:   send_request(ACT_LOAD, rows[r].start_val, rows[r].length_val);
                default:    send_request(ACT_FINISH, 0, 0, rows[r].typed, rows[r].typed_res);
            endcase
        end

        // random sequences of loads closed by a finish
        while (items < N_RANDOM) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0:       write_image_size('0);
                    1:       write_image_size(SIZE_MAX);
                    2:       write_image_size($urandom_range(0, 400));
                    default: write_image_size({1'($urandom), 32'($urandom)});
                endcase
            end
            if (items > N_RANDOM - 40) quiet = 1'b1;
            wide = ($urandom_range(0, 3) == 0);
            span = wide ? 0 : $urandom_range(20, 400);
            nload = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 8);
            // long hold-off on the result side with finishes piling up
            if (items > 80 && items < 120 && !hold_req && cycles > 0) begin
                hold_req = 1'b1;
                repeat (8) begin
                    send_request(ACT_LOAD, pick_value(0, 300), $urandom_range(0, 40));
                    send_request(ACT_FINISH, $urandom, $urandom);
                end
                drain_results();
            end
            for (int k = 0; k < nload; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_request(ACT_LOAD, $urandom, $urandom);
                else
                    send_request(ACT_LOAD, pick_value(wide, span),
                                 wide ? $urandom : $urandom_range(0, 60));
            end
            send_request(ACT_FINISH, $urandom, $urandom);
            if (items > 200 && items < 215) drain_results();
        end

        // wait for the tail of the run
        drain_results();
        repeat (50) @(negedge i_clk);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
